// ----- rtl/kdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants for the four-key debounce and long-press block.
// ----------------------------------------------------------------------------
package kdlp_pkg;

    localparam int NKEYS = 4;
    localparam int HOLD_W = 16;
    localparam int DEB_W = 2;
    localparam int EVT_W = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [HOLD_W-1:0] HOLD_MAX = 16'hFFFF;
    localparam logic [HOLD_W-1:0] LONG_TICKS_RST = 16'd200;
    localparam logic [DEB_W-1:0] DEB_TICKS_RST = 2'd2;

    // the two combo keys
    localparam int KEY_A = 0;
    localparam int KEY_B = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_TICKS = 1'b0,
        CFG_DEB_TICKS  = 1'b1
    } t_cfg_idx;

    typedef enum logic [EVT_W-1:0] {
        EV_NONE       = 3'd0,
        EV_K1_SHORT   = 3'd1,
        EV_K2_SHORT   = 3'd2,
        EV_K3_SHORT   = 3'd3,
        EV_K4_SHORT   = 3'd4,
        EV_K1_LONG    = 3'd5,
        EV_COMBO_LONG = 3'd6
    } t_event;

    // per-key status for one tick, seen by the event logic
    typedef struct packed {
        logic              accept;      // stable level changed this tick
        logic              release_ev;  // stable level went to released
        logic              stable_prev;
        logic              stable;
        logic [HOLD_W-1:0] held;
        logic              long_prev;
        logic              long_cur;    // long flag after a level change cleared it
    } t_key_stat;

endpackage

// ----- rtl/kdlp_if.sv -----
// ----------------------------------------------------------------------------
// kdlp channel interfaces
// Scan tick request channel and event result channel, valid/ready.
// ----------------------------------------------------------------------------
interface kdlp_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] raw_keys;
    logic       event_taken;

    modport source (output valid, output raw_keys, output event_taken, input ready);
    modport sink   (input valid, input raw_keys, input event_taken, output ready);
endinterface

interface kdlp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] pending_event;
    logic       event_posted;

    modport source (output valid, output pending_event, output event_posted, input ready);
    modport sink   (input valid, input pending_event, input event_posted, output ready);
endinterface

// ----- rtl/kdlp_key_deb.sv -----
// ----------------------------------------------------------------------------
// kdlp_key_deb
// Debounce, stable level and hold counter for one key.
// ----------------------------------------------------------------------------
module kdlp_key_deb (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_lvl,
    input  logic [kdlp_pkg::DEB_W-1:0] i_deb_ticks,
    input  logic                      i_set_long,
    output kdlp_pkg::t_key_stat       o_stat
);
    import kdlp_pkg::*;

    logic              r_last;
    logic              r_stable;
    logic [DEB_W-1:0]  r_settle;
    logic [HOLD_W-1:0] r_held;
    logic              r_long;

    logic              n_stable;
    logic [DEB_W-1:0]  n_settle;
    logic [HOLD_W-1:0] n_held;
    logic              n_long;
    logic              accept;
    logic [HOLD_W-1:0] held_base;

    always_comb begin
        if (i_lvl == r_last) begin
            n_settle = (r_settle < i_deb_ticks) ? r_settle + DEB_W'(1) : r_settle;
        end else begin
            n_settle = '0;
        end
        accept    = (n_settle >= i_deb_ticks) && (i_lvl != r_stable);
        n_stable  = accept ? i_lvl : r_stable;
        held_base = accept ? '0 : r_held;
        n_held    = (!n_stable && held_base < HOLD_MAX) ? held_base + HOLD_W'(1) : held_base;
        n_long    = i_set_long ? 1'b1 : (accept ? 1'b0 : r_long);

        o_stat.accept      = accept;
        o_stat.release_ev  = accept && i_lvl;
        o_stat.stable_prev = r_stable;
        o_stat.stable      = n_stable;
        o_stat.held        = n_held;
        o_stat.long_prev   = r_long;
        o_stat.long_cur    = accept ? 1'b0 : r_long;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b1;
            r_stable <= 1'b1;
            r_settle <= '0;
            r_held   <= '0;
            r_long   <= 1'b0;
        end else if (i_en) begin
            r_last   <= i_lvl;
            r_stable <= n_stable;
            r_settle <= n_settle;
            r_held   <= n_held;
            r_long   <= n_long;
        end
    end

endmodule

// ----- rtl/kdlp_event.sv -----
// ----------------------------------------------------------------------------
// kdlp_event
// Short, long and combo event decisions and the one-slot mailbox.
// ----------------------------------------------------------------------------
module kdlp_event (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_taken,
    input  logic [kdlp_pkg::HOLD_W-1:0]  i_long_ticks,
    input  kdlp_pkg::t_key_stat          i_stat [kdlp_pkg::NKEYS],
    output logic [kdlp_pkg::NKEYS-1:0]   o_set_long,
    output logic [kdlp_pkg::EVT_W-1:0]   o_pending,
    output logic                         o_posted
);
    import kdlp_pkg::*;

    logic   r_combo;
    t_event r_mbox;

    logic   n_combo;
    t_event n_mbox;
    t_event mbox_in;
    t_event req;
    logic   combo_run;
    logic   stable_b;
    logic   long_a;
    logic   long_b;
    logic   empty;

    always_comb begin
        mbox_in    = i_taken ? EV_NONE : r_mbox;
        empty      = (mbox_in == EV_NONE);
        req        = EV_NONE;
        combo_run  = r_combo;
        stable_b   = 1'b0;
        o_set_long = '0;

        // scan order matters: the first request wins, combo clears mid-scan
        for (int k = 0; k < NKEYS; k++) begin
            if (i_stat[k].release_ev) begin
                if (!i_stat[k].long_prev && !combo_run && req == EV_NONE) begin
                    req = t_event'(EVT_W'(EV_K1_SHORT) + EVT_W'(k));
                end
                stable_b = (k == KEY_B) ? i_stat[KEY_B].stable : i_stat[KEY_B].stable_prev;
                if (i_stat[KEY_A].stable && stable_b) begin
                    combo_run = 1'b0;
                end
            end
        end

        long_a  = i_stat[KEY_A].held >= i_long_ticks;
        long_b  = i_stat[KEY_B].held >= i_long_ticks;
        n_combo = combo_run;
        if (!i_stat[KEY_A].stable && !i_stat[KEY_B].stable) begin
            if (!combo_run && long_a && long_b) begin
                n_combo            = 1'b1;
                o_set_long[KEY_A] = 1'b1;
                o_set_long[KEY_B] = 1'b1;
                if (req == EV_NONE) begin
                    req = EV_COMBO_LONG;
                end
            end
        end else if (!i_stat[KEY_A].stable && !i_stat[KEY_A].long_cur && long_a) begin
            o_set_long[KEY_A] = 1'b1;
            if (req == EV_NONE) begin
                req = EV_K1_LONG;
            end
        end

        n_mbox    = (empty && req != EV_NONE) ? req : mbox_in;
        o_pending = n_mbox;
        o_posted  = empty && (n_mbox != EV_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_combo <= 1'b0;
            r_mbox  <= EV_NONE;
        end else if (i_en) begin
            r_combo <= n_combo;
            r_mbox  <= n_mbox;
        end
    end

endmodule

// ----- rtl/key_debounce_long_press_detector.sv -----
// ----------------------------------------------------------------------------
// key_debounce_long_press_detector
// Four active-low keys are debounced each scan tick request; short, key-1 long
// and key-1+key-4 combo long events go into a one-slot mailbox that the
// consumer empties with event_taken. Every request gives exactly one result:
// the mailbox content after the tick and whether an event was posted. The
// block takes one request per clock unless a result waits untaken; a request
// is held in the input register and its result is loaded into the result
// register when it advances. All key state is updated in that single pass,
// and a waiting result blocks the next request while the result register
// is full and the consumer has not taken it.
// Registers long_press_ticks (index 0) and debounce_ticks (index 1) must be
// written only while the block is idle.
// ----------------------------------------------------------------------------
module key_debounce_long_press_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    kdlp_in_if.sink                          i_key,
    kdlp_out_if.source                       o_evt,
    input  logic                             i_cfg_we,
    input  logic [kdlp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kdlp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import kdlp_pkg::*;

    logic [HOLD_W-1:0] r_long_thr;
    logic [DEB_W-1:0]  r_deb_ticks;

    logic              r_in_valid;
    logic [NKEYS-1:0]  r_raw;
    logic              r_taken;

    logic              r_out_valid;
    logic [EVT_W-1:0]  r_pending;
    logic              r_posted;

    logic              advance;
    t_key_stat         stat [NKEYS];
    logic [NKEYS-1:0]  set_long;
    logic [EVT_W-1:0]  n_pending;
    logic              n_posted;

    assign advance     = r_in_valid && (!r_out_valid || o_evt.ready);
    assign i_key.ready = !r_in_valid || advance;

    assign o_evt.valid         = r_out_valid;
    assign o_evt.pending_event = r_pending;
    assign o_evt.event_posted  = r_posted;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_thr  <= LONG_TICKS_RST;
            r_deb_ticks <= DEB_TICKS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LONG_TICKS: r_long_thr  <= i_cfg_data[HOLD_W-1:0];
                CFG_DEB_TICKS:  r_deb_ticks <= i_cfg_data[DEB_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_key.ready) begin
            r_in_valid <= i_key.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_key.valid && i_key.ready) begin
            r_raw   <= i_key.raw_keys;
            r_taken <= i_key.event_taken;
        end
    end

    for (genvar k = 0; k < NKEYS; k++) begin : g_key
        kdlp_key_deb u_key (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (advance),
            .i_lvl       (r_raw[k]),
            .i_deb_ticks (r_deb_ticks),
            .i_set_long  (set_long[k]),
            .o_stat      (stat[k])
        );
    end

    kdlp_event u_event (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_taken      (r_taken),
        .i_long_ticks (r_long_thr),
        .i_stat       (stat),
        .o_set_long   (set_long),
        .o_pending    (n_pending),
        .o_posted     (n_posted)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pending <= n_pending;
            r_posted  <= n_posted;
        end
    end

endmodule

// ----- rtl/kdlp_checker.sv -----
// ----------------------------------------------------------------------------
// kdlp_checker
// Port-level checks for the key debounce and long-press block.
// ----------------------------------------------------------------------------
module kdlp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_pending,
    input logic       i_posted
);
    import kdlp_pkg::*;

    // a posted event must be visible in the mailbox
    a_posted_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_posted) |-> (i_pending != EV_NONE))
        else $error("event posted with empty mailbox");

    // only defined event codes leave the block
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pending <= EV_COMBO_LONG))
        else $error("undefined event code");

    // a request taken into an empty pipe reaches the result register through the input register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> ##1 i_out_valid)
        else $error("result missing after request");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_pending)
                                           && $stable(i_posted)))
        else $error("stalled result changed");

endmodule

bind key_debounce_long_press_detector kdlp_checker u_kdlp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_key.valid),
    .i_in_ready  (i_key.ready),
    .i_out_valid (o_evt.valid),
    .i_out_ready (o_evt.ready),
    .i_pending   (o_evt.pending_event),
    .i_posted    (o_evt.event_posted)
);
